// ===== sv/c_comment_define_masker_defines.svh =====
// Assertion macros shared by the masker checker
`ifndef C_COMMENT_DEFINE_MASKER_DEFINES_SVH
`define C_COMMENT_DEFINE_MASKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet in reset
`define CCDM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet in reset
`define CCDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ccdm_pkg.sv =====
// Shared types, character constants and keyword table of the masker
`timescale 1ns / 1ps
package ccdm_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // Index of the final keyword character ("#define" has seven)
  localparam logic [2:0] KW_LAST = 3'd6;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_OPEN_EOF = 2'd2
  } status_e;

  // One burst of results: a prefix (held slash or keyword characters) and an optional tail
  typedef struct packed {
    logic       pre_slash;
    logic [2:0] pre_len;
    logic       pre_code;
    logic       tail_en;
    logic [7:0] tail_char;
    logic       tail_code;
    logic       ends_line;
    status_e    status;
  } desc_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h23; // #
      3'd1:    ch = 8'h64; // d
      3'd2:    ch = 8'h65; // e
      3'd3:    ch = 8'h66; // f
      3'd4:    ch = 8'h69; // i
      3'd5:    ch = 8'h6E; // n
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/ccdm_if.sv =====
// Valid/ready channel interfaces for the masker input and result streams
`timescale 1ns / 1ps
interface ccdm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       has_char;
  logic       line_end;
  logic       file_end;

  modport source (output valid, character, has_char, line_end, file_end, input ready);
  modport sink (input valid, character, has_char, line_end, file_end, output ready);
  modport monitor (input valid, ready, character, has_char, line_end, file_end);
endinterface

interface ccdm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       valid_code;
  logic       ends_line;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_char, valid_code, ends_line, status, last, input ready);
  modport sink (input valid, out_char, valid_code, ends_line, status, last, output ready);
  modport monitor (input valid, ready, out_char, valid_code, ends_line, status, last);
endinterface

// ===== sv/ccdm_front.sv =====
// Front end: lexer state, classifies each input character into a result burst
`timescale 1ns / 1ps
module ccdm_front import ccdm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ccdm_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output desc_t         desc_o
);

  localparam logic [3:0] M_NORMAL   = 4'd0;
  localparam logic [3:0] M_BLOCK    = 4'd1;
  localparam logic [3:0] M_STR      = 4'd2;
  localparam logic [3:0] M_STR_ESC  = 4'd3;
  localparam logic [3:0] M_CH_OPEN  = 4'd4;
  localparam logic [3:0] M_CH_ESC   = 4'd5;
  localparam logic [3:0] M_CH_CLOSE = 4'd6;
  localparam logic [3:0] M_LINECOM  = 4'd7;
  localparam logic [3:0] M_DEFINE   = 4'd8;

  logic [3:0] mode_q, mode_d;
  logic [2:0] pcnt_q, pcnt_d;
  logic       pslash_q, pslash_d;
  logic       star_q, star_d;

  logic [7:0] c;
  logic       has, le, fe, active, accept;
  logic       kw_hit;
  logic [2:0] rel_len;
  logic       nc_tail_en, nc_tail_code, nc_hold_slash, nc_hold_hash;
  logic [3:0] nc_mode;
  desc_t      d;

  assign c      = in_i.character;
  assign has    = in_i.has_char;
  assign fe     = in_i.file_end;
  assign le     = in_i.line_end | in_i.file_end;
  assign active = has | le;
  assign accept = in_i.valid & in_i.ready;

  assign in_i.ready = ~full_i;

  assign kw_hit  = (c == kw_char(pcnt_q));
  assign rel_len = (pcnt_q > KW_LAST) ? KW_LAST : pcnt_q;

  // Plain code character: open a literal, hold a possible prefix, or pass as code
  always_comb begin
    nc_tail_en    = 1'b0;
    nc_tail_code  = 1'b0;
    nc_hold_slash = 1'b0;
    nc_hold_hash  = 1'b0;
    nc_mode       = M_NORMAL;
    if (c == CH_SQUOTE) begin
      nc_tail_en = 1'b1;
      nc_mode    = M_CH_OPEN;
    end else if (c == CH_DQUOTE) begin
      nc_tail_en = 1'b1;
      nc_mode    = M_STR;
    end else if (c == CH_SLASH && !le) begin
      nc_hold_slash = 1'b1;
    end else if (c == CH_HASH && !le) begin
      nc_hold_hash = 1'b1;
    end else begin
      nc_tail_en   = 1'b1;
      nc_tail_code = 1'b1;
    end
  end

  always_comb begin
    d.pre_slash = 1'b0;
    d.pre_len   = 3'd0;
    d.pre_code  = 1'b1;
    d.tail_en   = 1'b0;
    d.tail_char = c;
    d.tail_code = 1'b0;
    d.ends_line = le;
    d.status    = ST_OK;
    mode_d      = mode_q;
    pcnt_d      = pcnt_q;
    pslash_d    = pslash_q;
    star_d      = star_q;

    if (has) begin
      unique case (mode_q)
        M_BLOCK: begin
          d.tail_en = 1'b1;
          if (star_q && c == CH_SLASH) begin
            mode_d = M_NORMAL;
            star_d = 1'b0;
          end else begin
            star_d = (c == CH_STAR);
          end
        end
        M_STR: begin
          d.tail_en = 1'b1;
          if (c == CH_DQUOTE) mode_d = M_NORMAL;
          else if (c == CH_BSLASH) mode_d = M_STR_ESC;
        end
        M_STR_ESC: begin
          d.tail_en = 1'b1;
          mode_d    = M_STR;
        end
        M_CH_OPEN: begin
          d.tail_en = 1'b1;
          mode_d    = (c == CH_BSLASH) ? M_CH_ESC : M_CH_CLOSE;
        end
        M_CH_ESC: begin
          d.tail_en = 1'b1;
          mode_d    = M_CH_CLOSE;
        end
        M_CH_CLOSE: begin
          d.tail_en = 1'b1;
          if (c != CH_SQUOTE) d.status = ST_BAD_CHAR;
          mode_d = M_NORMAL;
        end
        M_LINECOM, M_DEFINE: begin
          d.tail_en = 1'b1;
        end
        default: begin
          mode_d = M_NORMAL;
          if (pslash_q && (c == CH_SLASH || c == CH_STAR)) begin
            // comment opener: slash and this character both masked
            d.pre_slash = 1'b1;
            d.pre_len   = 3'd1;
            d.pre_code  = 1'b0;
            d.tail_en   = 1'b1;
            mode_d      = (c == CH_SLASH) ? M_LINECOM : M_BLOCK;
            star_d      = 1'b0;
            pcnt_d      = 3'd0;
            pslash_d    = 1'b0;
          end else if (!pslash_q && pcnt_q != 3'd0 && pcnt_q <= KW_LAST && kw_hit) begin
            if (pcnt_q == KW_LAST) begin
              d.pre_len  = KW_LAST;
              d.pre_code = 1'b0;
              d.tail_en  = 1'b1;
              mode_d     = M_DEFINE;
              pcnt_d     = 3'd0;
            end else if (le) begin
              // prefix cut by the line end: release as code
              d.pre_len   = pcnt_q;
              d.tail_en   = 1'b1;
              d.tail_code = 1'b1;
              pcnt_d      = 3'd0;
            end else begin
              pcnt_d = pcnt_q + 3'd1;
            end
          end else begin
            // release anything held, then treat this as a plain character
            if (pslash_q) begin
              d.pre_slash = 1'b1;
              d.pre_len   = 3'd1;
            end else if (pcnt_q <= KW_LAST) begin
              d.pre_len = pcnt_q;
            end
            d.tail_en   = nc_tail_en;
            d.tail_code = nc_tail_code;
            mode_d      = nc_mode;
            pslash_d    = nc_hold_slash;
            pcnt_d      = (nc_hold_slash || nc_hold_hash) ? 3'd1 : 3'd0;
          end
        end
      endcase
    end else begin
      // empty line mark: release held prefix as code, then the marker
      d.pre_slash = pslash_q;
      d.pre_len   = pslash_q ? 3'd1 : rel_len;
      d.tail_en   = 1'b1;
      d.tail_char = 8'h00;
      pcnt_d      = 3'd0;
      pslash_d    = 1'b0;
    end

    if (le) begin
      star_d = 1'b0;
      unique case (mode_d) inside
        M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
          d.status = ST_BAD_CHAR;
          mode_d   = M_NORMAL;
        end
        M_STR_ESC: mode_d = M_STR;
        M_LINECOM, M_DEFINE: begin
          if (!(has && c == CH_BSLASH)) mode_d = M_NORMAL;
        end
        default: ;
      endcase
    end

    if (fe) begin
      if (mode_d == M_BLOCK || mode_d == M_STR) d.status = ST_OPEN_EOF;
      mode_d   = M_NORMAL;
      pcnt_d   = 3'd0;
      pslash_d = 1'b0;
      star_d   = 1'b0;
    end
  end

  assign push_o = accept & active & (d.tail_en | (d.pre_len != 3'd0));
  assign desc_o = d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_NORMAL;
      pcnt_q   <= 3'd0;
      pslash_q <= 1'b0;
      star_q   <= 1'b0;
    end else if (accept && active) begin
      mode_q   <= mode_d;
      pcnt_q   <= pcnt_d;
      pslash_q <= pslash_d;
      star_q   <= star_d;
    end
  end

endmodule

// ===== sv/ccdm_fifo.sv =====
// Short burst queue between the classifying front and the expanding back
`timescale 1ns / 1ps
module ccdm_fifo import ccdm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output desc_t head_o
);

  desc_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= next_ptr(wr_q);
      if (do_pop) rd_q <= next_ptr(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

// ===== sv/ccdm_back.sv =====
// Back end: expands each queued burst into results, one per cycle while out_o is ready, into the output register
`timescale 1ns / 1ps
module ccdm_back import ccdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  desc_t       head_i,
  input  logic        empty_i,
  output logic        pop_o,
  ccdm_out_if.source  out_o
);

  logic [2:0] idx_q;
  logic       oval_q;
  logic [7:0] char_q;
  logic       code_q, ends_q, last_q;
  status_e    stat_q;

  logic       in_pre, is_final, load;
  logic [7:0] r_char;

  assign in_pre   = (idx_q < head_i.pre_len);
  assign r_char   = in_pre ? (head_i.pre_slash ? CH_SLASH : kw_char(idx_q)) : head_i.tail_char;
  assign is_final = in_pre ? (!head_i.tail_en && idx_q == head_i.pre_len - 3'd1) : 1'b1;
  assign load     = ~empty_i & (~oval_q | out_o.ready);
  assign pop_o    = load & is_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 3'd0;
      oval_q <= 1'b0;
    end else begin
      if (load) begin
        oval_q <= 1'b1;
        idx_q  <= is_final ? 3'd0 : idx_q + 3'd1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= r_char;
      code_q <= in_pre ? head_i.pre_code : head_i.tail_code;
      ends_q <= ~in_pre & head_i.ends_line;
      stat_q <= in_pre ? ST_OK : head_i.status;
      last_q <= is_final;
    end
  end

  assign out_o.valid      = oval_q;
  assign out_o.out_char   = char_q;
  assign out_o.valid_code = code_q;
  assign out_o.ends_line  = ends_q;
  assign out_o.status     = stat_q;
  assign out_o.last       = last_q;

endmodule

// ===== sv/c_comment_define_masker.sv =====
// Top level of the C comment, literal and #define masker
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    character, has_char, line_end, file_end
//   out_o    out  valid / ready    out_char, valid_code, ends_line, status, last
//
// One input transfer per cycle while the burst queue has room; each item becomes 0 to 7
// results, and the back end delivers one result per cycle from its output register while out_o is
// ready. An item that yields one result passes through the queue, then the output register; a held
// "#define" prefix or slash comes out later as a burst of up to seven results, during which input
// stalls once the two-entry queue fills. Reset clears lexer state, queue and output register.
`timescale 1ns / 1ps
module c_comment_define_masker import ccdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccdm_in_if.sink    in_i,
  ccdm_out_if.source out_o
);

  desc_t push_desc, head_desc;
  logic  push, pop, full, empty;

  ccdm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  ccdm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_desc)
  );

  ccdm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_desc),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== sv/ccdm_checker.sv =====
// Port-level checker for the masker, bound to the top level
`timescale 1ns / 1ps
`include "c_comment_define_masker_defines.svh"
module ccdm_checker import ccdm_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  ccdm_in_if.sink     in_i,
  ccdm_out_if.source  out_o
);

  // input ready always resolves to a known level
  `CCDM_ASSERT_SAME(a_in_ready_known, 1'b1, !$isunknown(in_i.ready), "input ready unknown")
  // hold a stalled result
  `CCDM_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.out_char) && $stable(out_o.valid_code) && $stable(out_o.status) && $stable(out_o.last), "stalled result changed")
  // a line end only on the final result of its item
  `CCDM_ASSERT_SAME(a_eol_last, out_o.valid && out_o.ends_line, out_o.last, "line end on a non-final result")
  // an open comment or string is flagged only at a line end
  `CCDM_ASSERT_SAME(a_eof_eol, out_o.valid && out_o.status == ST_OPEN_EOF, out_o.ends_line && !out_o.valid_code, "open-at-end flag off a line end")
  // status carries a defined code
  `CCDM_ASSERT_SAME(a_stat_code, out_o.valid, out_o.status == ST_OK || out_o.status == ST_BAD_CHAR || out_o.status == ST_OPEN_EOF, "undefined status code")

endmodule

bind c_comment_define_masker ccdm_checker u_ccdm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
